// File: hw/rtl/erws_pkg.sv
package erws_pkg;

   localparam int unsigned NUM_SLOTS_DEFAULT = 16;
   localparam int unsigned CODE_SPAN = 256;

   localparam logic [2:0] OP_HANDLE = 3'd0;
   localparam logic [2:0] OP_RECORD = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_CLEAR  = 3'd3;
   localparam logic [2:0] OP_RESET  = 3'd4;

   localparam logic [2:0] STRAT_IGNORE  = 3'd0;
   localparam logic [2:0] STRAT_RETRY   = 3'd1;
   localparam logic [2:0] STRAT_DEGRADE = 3'd2;
   localparam logic [2:0] STRAT_HALT    = 3'd3;
   localparam logic [2:0] STRAT_REBOOT  = 3'd4;

   localparam logic [1:0] CSR_STRATEGY    = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_BASE_DELAY  = 2'd2;

   localparam logic [2:0]  STRATEGY_RESET    = STRAT_IGNORE;
   localparam logic [5:0]  RETRY_LIMIT_RESET = 6'd3;
   localparam logic [15:0] BASE_DELAY_RESET  = 16'd10;
   localparam logic [15:0] RUN_MAX           = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  strategy;
      logic [5:0]  retry_limit;
      logic [15:0] base_delay_ms;
   } cfg_type;

   typedef struct packed {
      logic rd_en;
      logic rec;
      logic fire;
      logic clr_op;
   } hist_ctl_type;

   typedef struct packed {
      logic        proceed;
      logic        recovered;
      logic        error_reported;
      logic        delay_valid;
      logic [31:0] delay_ms;
      logic        reboot_request;
      logic [31:0] slot_count;
      logic [31:0] total_count;
      logic [7:0]  latest_error;
      logic [15:0] run_length;
   } resp_type;

endpackage

// File: hw/rtl/erws_hist.sv
module erws_hist #(
   parameter int unsigned NUM_SLOTS = erws_pkg::NUM_SLOTS_DEFAULT,
   parameter int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  erws_pkg::hist_ctl_type ctl,
   input  logic [7:0]            rd_code,
   input  logic [3:0]            rd_slot,
   output logic [31:0]           slot_count
);
   import erws_pkg::*;

   logic [AW-1:0] mod_lut [CODE_SPAN];

   for (genvar i = 0; i < CODE_SPAN; i++) begin : g_mod
      localparam int unsigned ModVal = i % NUM_SLOTS;
      assign mod_lut[i] = AW'(ModVal);
   end

   logic [31:0]          hist_mem_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [31:0]          inc_rd_ff;
   logic [31:0]          slot_rd_ff;
   logic [31:0]          byp_data_ff;
   logic                 inc_byp_ff;
   logic                 slot_byp_ff;
   logic                 slot_ok_ff;
   logic [AW-1:0]        inc_addr_ff;
   logic [AW-1:0]        slot_addr_ff;

   logic [8:0]    slot_wide;
   logic [AW-1:0] rd_inc_addr;
   logic [AW-1:0] rd_slot_addr;
   logic          rd_slot_ok;
   logic          wr_now;
   logic          clr_now;
   logic [31:0]   inc_val;
   logic [31:0]   slot_val;
   logic [31:0]   inc_next;

   assign slot_wide    = 9'(rd_slot);
   assign rd_slot_addr = slot_wide[AW-1:0];
   assign rd_slot_ok   = slot_wide < 9'(NUM_SLOTS);
   assign rd_inc_addr  = mod_lut[rd_code];

   assign wr_now  = ctl.fire && ctl.rec;
   assign clr_now = ctl.fire && ctl.clr_op;

   assign inc_val = !valid_ff[inc_addr_ff] ? 32'd0 : (inc_byp_ff ? byp_data_ff : inc_rd_ff);
   assign inc_next = inc_val + 32'd1;

   always_comb begin
      slot_val = 32'd0;
      if (slot_ok_ff) begin
         if (valid_ff[slot_addr_ff]) begin
            slot_val = slot_byp_ff ? byp_data_ff : slot_rd_ff;
         end
      end
   end

   always_comb begin
      slot_count = slot_val;
      if (ctl.clr_op || !slot_ok_ff) begin
         slot_count = 32'd0;
      end else if (ctl.rec && (slot_addr_ff == inc_addr_ff)) begin
         slot_count = inc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         inc_rd_ff    <= hist_mem_ff[rd_inc_addr];
         slot_rd_ff   <= hist_mem_ff[rd_slot_addr];
         inc_addr_ff  <= rd_inc_addr;
         slot_addr_ff <= rd_slot_addr;
         slot_ok_ff   <= rd_slot_ok;
         inc_byp_ff   <= wr_now && (inc_addr_ff == rd_inc_addr);
         slot_byp_ff  <= wr_now && (inc_addr_ff == rd_slot_addr);
         byp_data_ff  <= inc_next;
      end
      if (wr_now) begin
         hist_mem_ff[inc_addr_ff] <= inc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr_now) begin
         valid_ff <= '0;
      end else if (wr_now) begin
         valid_ff[inc_addr_ff] <= 1'b1;
      end
   end

endmodule

// File: hw/rtl/erws_core.sv
module erws_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [2:0]         op,
   input  logic [7:0]         code,
   input  erws_pkg::cfg_type  cfg,
   input  logic [31:0]        slot_count,
   output erws_pkg::resp_type resp
);
   import erws_pkg::*;

   logic [31:0] total_ff, total_in;
   logic [7:0]  last_ff, last_in;
   logic [15:0] cons_ff, cons_in;
   logic [31:0] delay_ff, delay_in;
   logic        proceed, recovered, reported, dvalid, reboot;
   logic [15:0] shift;

   always_comb begin
      total_in  = total_ff;
      last_in   = last_ff;
      cons_in   = cons_ff;
      delay_in  = delay_ff;
      proceed   = 1'b0;
      recovered = 1'b0;
      reported  = 1'b0;
      dvalid    = 1'b0;
      reboot    = 1'b0;
      shift     = 16'd0;
      case (op)
         OP_HANDLE: begin
            if (code == 8'd0) begin
               recovered = cons_ff != 16'd0;
               cons_in   = 16'd0;
               proceed   = 1'b1;
            end else begin
               total_in = total_ff + 32'd1;
               last_in  = code;
               cons_in  = (cons_ff == RUN_MAX) ? cons_ff : cons_ff + 16'd1;
               reported = 1'b1;
               case (cfg.strategy)
                  STRAT_IGNORE, STRAT_DEGRADE: begin
                     proceed = 1'b1;
                  end
                  STRAT_RETRY: begin
                     shift = cons_in - 16'd1;
                     if (cons_in <= 16'(cfg.retry_limit)) begin
                        delay_in = (shift[15:5] != 11'd0) ? 32'd0 :
                                   (32'(cfg.base_delay_ms) << shift[4:0]);
                        dvalid   = 1'b1;
                        proceed  = 1'b1;
                     end
                  end
                  STRAT_REBOOT: begin
                     reboot = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         OP_RECORD: begin
            total_in = total_ff + 32'd1;
            last_in  = code;
         end
         OP_CLEAR: begin
            total_in = 32'd0;
            last_in  = 8'd0;
         end
         OP_RESET: begin
            cons_in  = 16'd0;
            delay_in = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      resp.proceed        = proceed;
      resp.recovered      = recovered;
      resp.error_reported = reported;
      resp.delay_valid    = dvalid;
      resp.delay_ms       = delay_in;
      resp.reboot_request = reboot;
      resp.slot_count     = slot_count;
      resp.total_count    = total_in;
      resp.latest_error   = last_in;
      resp.run_length     = cons_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd0;
         last_ff  <= 8'd0;
         cons_ff  <= 16'd0;
         delay_ff <= 32'd0;
      end else if (fire) begin
         total_ff <= total_in;
         last_ff  <= last_in;
         cons_ff  <= cons_in;
         delay_ff <= delay_in;
      end
   end

endmodule

// File: hw/rtl/error_recovery_with_stats_top.sv
// A request waits in the s1 registers until it fires and its result is then
// registered in rsp_ff. One request per cycle unless the output stalls; the
// histogram read is registered at request transfer, counters update on fire.
// Reset (synchronous, active high) clears all counters and the histogram
// valid bits at once, with no clearing pass, and reloads config defaults.
module error_recovery_with_stats_top #(
   parameter int unsigned NUM_SLOTS = erws_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_error_code,
   input  logic [3:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_proceed,
   output logic        rsp_recovered,
   output logic        rsp_error_reported,
   output logic        rsp_delay_valid,
   output logic [31:0] rsp_delay_ms,
   output logic        rsp_reboot_request,
   output logic [31:0] rsp_slot_count,
   output logic [31:0] rsp_total_count,
   output logic [7:0]  rsp_latest_error,
   output logic [15:0] rsp_run_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import erws_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   logic         s1_valid_ff, s1_valid_in;
   logic [2:0]   s1_op_ff;
   logic [7:0]   s1_code_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   resp_type     rsp_ff;
   resp_type     resp;
   hist_ctl_type hctl;
   logic [31:0]  slot_count;
   logic         accept, fire, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign hctl.rd_en  = accept;
   assign hctl.fire   = fire;
   assign hctl.rec    = ((s1_op_ff == OP_HANDLE) && (s1_code_ff != 8'd0)) ||
                        (s1_op_ff == OP_RECORD);
   assign hctl.clr_op = s1_op_ff == OP_CLEAR;

   erws_hist #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_hist (
      .clock      (clock),
      .reset      (reset),
      .ctl        (hctl),
      .rd_code    (req_error_code),
      .rd_slot    (req_slot_index),
      .slot_count (slot_count)
   );

   erws_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .op         (s1_op_ff),
      .code       (s1_code_ff),
      .cfg        (cfg_ff),
      .slot_count (slot_count),
      .resp       (resp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STRATEGY:    cfg_in.strategy      = csr_wdata[2:0];
            CSR_RETRY_LIMIT: cfg_in.retry_limit   = csr_wdata[5:0];
            CSR_BASE_DELAY:  cfg_in.base_delay_ms = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strategy      <= STRATEGY_RESET;
         cfg_ff.retry_limit   <= RETRY_LIMIT_RESET;
         cfg_ff.base_delay_ms <= BASE_DELAY_RESET;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_op;
         s1_code_ff <= req_error_code;
      end
      if (fire) begin
         rsp_ff <= resp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_proceed        = rsp_ff.proceed;
   assign rsp_recovered      = rsp_ff.recovered;
   assign rsp_error_reported = rsp_ff.error_reported;
   assign rsp_delay_valid    = rsp_ff.delay_valid;
   assign rsp_delay_ms       = rsp_ff.delay_ms;
   assign rsp_reboot_request = rsp_ff.reboot_request;
   assign rsp_slot_count     = rsp_ff.slot_count;
   assign rsp_total_count    = rsp_ff.total_count;
   assign rsp_latest_error   = rsp_ff.latest_error;
   assign rsp_run_length     = rsp_ff.run_length;

endmodule

// File: hw/rtl/erws_checker.sv
module erws_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_proceed,
   input logic rsp_recovered,
   input logic rsp_error_reported,
   input logic rsp_delay_valid,
   input logic rsp_reboot_request
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled result was dropped.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result is valid right after reset.");

   a_recover_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_recovered && rsp_error_reported))
      else $error("Recovery and error were flagged in the same transfer.");

   a_delay_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delay_valid |-> rsp_proceed && rsp_error_reported)
      else $error("A retry delay was issued without a reported error.");

   a_reboot_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reboot_request |-> !rsp_proceed && rsp_error_reported)
      else $error("A reboot request allowed the caller to proceed.");

endmodule

bind error_recovery_with_stats_top erws_checker u_checker (.*);
